### rtl/core/zbp_pkg.sv
package zbp_pkg;

  // Default store geometry and layer limit.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_STEPS  = 100;

  // Field widths.
  localparam int CH_W   = 16;
  localparam int NCH    = 4;
  localparam int PIX_W  = 64;
  localparam int POS_W  = 9;
  localparam int SIZE_W = 10;
  localparam int PCT_W  = 7;
  localparam int RAD_W  = 8;
  localparam int STEP_W = 7;
  localparam int MASK_W = 4;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 10;

  // Mapping arithmetic widths.
  localparam int NUM_W  = 34;  // signed numerator of one layer
  localparam int K_W    = 26;  // signed per-layer numerator increment
  localparam int M_W    = 24;  // signed 100 * D
  localparam int DVD_W  = 35;  // divider dividend and quotient
  localparam int DVS_W  = 25;  // divider divisor
  localparam int SUM_W  = 24;  // per-channel sum
  localparam int FRAC_W = 17;  // 65536 / steps

  localparam logic [DVD_W-1:0] FRAC_DIVIDEND = DVD_W'(32'h10000);
  localparam logic [SUM_W-1:0] CHROMA_FILL   = SUM_W'(16'h8000);

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_ZOOM_RADIUS = 3'd2,
    REG_STEP_COUNT  = 3'd3,
    REG_CHAN_MASK   = 3'd4,
    REG_COLOR_MODE  = 3'd5,
    REG_FRAME_W     = 3'd6,
    REG_FRAME_H     = 3'd7
  } cfg_reg_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP_A,
    ST_SETUP_B,
    ST_FRAC_WAIT,
    ST_LAYER_DIV,
    ST_LAYER_WAIT,
    ST_LAYER_READ,
    ST_LAYER_ACC,
    ST_ORIG_READ,
    ST_ORIG_WAIT,
    ST_SCALE,
    ST_DONE
  } zbp_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic store;
    logic load;
    logic setup_a;
    logic setup_b;
    logic frac_take;
    logic layer_start;
    logic layer_read;
    logic layer_acc;
    logic orig_read;
    logic scale;
  } zbp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic in_frame;
    logic div_done;
    logic last_layer;
    logic last_chan;
  } zbp_stat_t;

endpackage

### rtl/core/zbp_div.sv
module zbp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [zbp_pkg::DVD_W-1:0]  dividend_i,
  input  logic [zbp_pkg::DVS_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [zbp_pkg::DVD_W-1:0]  quotient_o
);

  localparam int DVD_W = zbp_pkg::DVD_W;
  localparam int DVS_W = zbp_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
    dvd_d  = {dvd_q[DVD_W-2:0], ge};
  end

  // Control of the bit-serial iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

### rtl/core/zbp_ctrl.sv
module zbp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               kind_i,
  input  zbp_pkg::zbp_stat_t stat_i,
  output zbp_pkg::zbp_cmd_t  cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  zbp_pkg::zbp_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zbp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      zbp_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i && !kind_i) begin
          cmd_o.store = 1'b1;
        end else if (start_i && stat_i.in_frame) begin
          cmd_o.load = 1'b1;
          state_d    = zbp_pkg::ST_SETUP_A;
        end
      end
      zbp_pkg::ST_SETUP_A: begin
        cmd_o.setup_a = 1'b1;
        state_d       = zbp_pkg::ST_SETUP_B;
      end
      zbp_pkg::ST_SETUP_B: begin
        cmd_o.setup_b = 1'b1;
        state_d       = zbp_pkg::ST_FRAC_WAIT;
      end
      zbp_pkg::ST_FRAC_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.frac_take = 1'b1;
          state_d         = zbp_pkg::ST_LAYER_DIV;
        end
      end
      zbp_pkg::ST_LAYER_DIV: begin
        cmd_o.layer_start = 1'b1;
        state_d           = zbp_pkg::ST_LAYER_WAIT;
      end
      zbp_pkg::ST_LAYER_WAIT: begin
        if (stat_i.div_done) begin
          state_d = zbp_pkg::ST_LAYER_READ;
        end
      end
      zbp_pkg::ST_LAYER_READ: begin
        cmd_o.layer_read = 1'b1;
        state_d          = zbp_pkg::ST_LAYER_ACC;
      end
      zbp_pkg::ST_LAYER_ACC: begin
        cmd_o.layer_acc = 1'b1;
        state_d = stat_i.last_layer ? zbp_pkg::ST_ORIG_READ : zbp_pkg::ST_LAYER_DIV;
      end
      zbp_pkg::ST_ORIG_READ: begin
        cmd_o.orig_read = 1'b1;
        state_d         = zbp_pkg::ST_ORIG_WAIT;
      end
      zbp_pkg::ST_ORIG_WAIT: begin
        state_d = zbp_pkg::ST_SCALE;
      end
      zbp_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        if (stat_i.last_chan) begin
          state_d = zbp_pkg::ST_DONE;
        end
      end
      zbp_pkg::ST_DONE: begin
        done_o  = 1'b1;
        state_d = zbp_pkg::ST_IDLE;
      end
      default: begin
        state_d = zbp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/zbp_datapath.sv
module zbp_datapath #(
  parameter int MAX_WIDTH  = zbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = zbp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_STEPS  = zbp_pkg::DEF_MAX_STEPS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  zbp_pkg::zbp_cmd_t           cmd_i,
  output zbp_pkg::zbp_stat_t          stat_o,
  input  logic                        cfg_we_i,
  input  logic [zbp_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [zbp_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic [zbp_pkg::POS_W-1:0]   pixel_x_i,
  input  logic [zbp_pkg::POS_W-1:0]   pixel_y_i,
  input  logic [zbp_pkg::PIX_W-1:0]   pixel_i,
  output logic [zbp_pkg::PIX_W-1:0]   result_o
);

  localparam int CH_W   = zbp_pkg::CH_W;
  localparam int NCH    = zbp_pkg::NCH;
  localparam int PIX_W  = zbp_pkg::PIX_W;
  localparam int POS_W  = zbp_pkg::POS_W;
  localparam int SIZE_W = zbp_pkg::SIZE_W;
  localparam int PCT_W  = zbp_pkg::PCT_W;
  localparam int RAD_W  = zbp_pkg::RAD_W;
  localparam int STEP_W = zbp_pkg::STEP_W;
  localparam int MASK_W = zbp_pkg::MASK_W;
  localparam int NUM_W  = zbp_pkg::NUM_W;
  localparam int K_W    = zbp_pkg::K_W;
  localparam int M_W    = zbp_pkg::M_W;
  localparam int DVD_W  = zbp_pkg::DVD_W;
  localparam int DVS_W  = zbp_pkg::DVS_W;
  localparam int SUM_W  = zbp_pkg::SUM_W;
  localparam int FRAC_W = zbp_pkg::FRAC_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GEO_W  = 13;
  localparam int PROD_W = SUM_W + FRAC_W;
  localparam int CH_IW  = $clog2(NCH);

  // Configuration registers.
  logic [PCT_W-1:0]  center_x_q, center_y_q;
  logic [RAD_W-1:0]  radius_q;
  logic [STEP_W-1:0] step_count_q;
  logic [MASK_W-1:0] chan_mask_q;
  logic              color_mode_q;
  logic [SIZE_W-1:0] frame_w_q, frame_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= PCT_W'(50);
      center_y_q   <= PCT_W'(50);
      radius_q     <= RAD_W'(10);
      step_count_q <= STEP_W'(10);
      chan_mask_q  <= MASK_W'(15);
      color_mode_q <= 1'b0;
      frame_w_q    <= SIZE_W'(512);
      frame_h_q    <= SIZE_W'(512);
    end else if (cfg_we_i) begin
      unique case (zbp_pkg::cfg_reg_e'(cfg_index_i))
        zbp_pkg::REG_CENTER_X:    center_x_q   <= cfg_data_i[PCT_W-1:0];
        zbp_pkg::REG_CENTER_Y:    center_y_q   <= cfg_data_i[PCT_W-1:0];
        zbp_pkg::REG_ZOOM_RADIUS: radius_q     <= cfg_data_i[RAD_W-1:0];
        zbp_pkg::REG_STEP_COUNT:  step_count_q <= cfg_data_i[STEP_W-1:0];
        zbp_pkg::REG_CHAN_MASK:   chan_mask_q  <= cfg_data_i[MASK_W-1:0];
        zbp_pkg::REG_COLOR_MODE:  color_mode_q <= cfg_data_i[0];
        zbp_pkg::REG_FRAME_W:     frame_w_q    <= cfg_data_i;
        zbp_pkg::REG_FRAME_H:     frame_h_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame size and layer count in use, saturated to their legal ranges.
  logic [SIZE_W-1:0] size_w, size_h;
  logic [STEP_W-1:0] steps;

  always_comb begin
    if (frame_w_q == '0) begin
      size_w = SIZE_W'(1);
    end else if (GEO_W'(frame_w_q) > GEO_W'(MAX_WIDTH)) begin
      size_w = SIZE_W'(MAX_WIDTH);
    end else begin
      size_w = frame_w_q;
    end
    if (frame_h_q == '0) begin
      size_h = SIZE_W'(1);
    end else if (GEO_W'(frame_h_q) > GEO_W'(MAX_HEIGHT)) begin
      size_h = SIZE_W'(MAX_HEIGHT);
    end else begin
      size_h = frame_h_q;
    end
    if (step_count_q == '0) begin
      steps = STEP_W'(1);
    end else if (GEO_W'(step_count_q) > GEO_W'(MAX_STEPS)) begin
      steps = STEP_W'(MAX_STEPS);
    end else begin
      steps = step_count_q;
    end
  end

  assign stat_o.in_frame = (SIZE_W'(pixel_x_i) < size_w) && (SIZE_W'(pixel_y_i) < size_h);

  // Latched item and per-item constants.
  logic [POS_W-1:0]      px_q, py_q;
  logic [STEP_W-1:0]     s_q;
  logic [15:0]           ps_x_q, ps_y_q;
  logic [16:0]           wp_x_q, wp_y_q;
  logic signed [NUM_W-1:0] p0_x_q, p0_y_q;
  logic signed [K_W-1:0]   k_x_q, k_y_q;
  logic signed [NUM_W-1:0] acc_x_q, acc_y_q;
  logic signed [M_W-1:0]   m_q, mstep_q;
  logic [STEP_W-1:0]     layer_q;
  logic [FRAC_W-1:0]     frac_q;
  logic signed [RAD_W-1:0] radius_s;

  assign radius_s = $signed(radius_q);

  // Current layer numerators and the rounding division operands.
  logic signed [NUM_W-1:0] n_x, n_y;
  logic [NUM_W-1:0]        mag_x, mag_y;
  logic [DVD_W-1:0]        dvd_x, dvd_y;
  logic [DVS_W-1:0]        dvs;
  logic                    d_pos;

  always_comb begin
    n_x   = p0_x_q + acc_x_q;
    n_y   = p0_y_q + acc_y_q;
    mag_x = n_x[NUM_W-1] ? NUM_W'(-n_x) : NUM_W'(n_x);
    mag_y = n_y[NUM_W-1] ? NUM_W'(-n_y) : NUM_W'(n_y);
    dvd_x = DVD_W'({mag_x, 1'b0}) + DVD_W'(unsigned'(m_q));
    dvd_y = DVD_W'({mag_y, 1'b0}) + DVD_W'(unsigned'(m_q));
    dvs   = DVS_W'({m_q, 1'b0});
    d_pos = !m_q[M_W-1] && (m_q != '0);
  end

  // Two dividers, one per axis; the x divider also forms 65536 / steps.
  logic             div_start_x, div_start_y;
  logic [DVD_W-1:0] div_dvd_x;
  logic [DVS_W-1:0] div_dvs_x;
  logic             done_x, done_y;
  logic [DVD_W-1:0] q_x, q_y;

  assign div_start_x = cmd_i.setup_b || cmd_i.layer_start;
  assign div_start_y = div_start_x;
  assign div_dvd_x   = cmd_i.setup_b ? zbp_pkg::FRAC_DIVIDEND : dvd_x;
  assign div_dvs_x   = cmd_i.setup_b ? DVS_W'(s_q) : dvs;

  zbp_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_x),
    .dividend_i (div_dvd_x),
    .divisor_i  (div_dvs_x),
    .done_o     (done_x),
    .quotient_o (q_x)
  );

  zbp_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_y),
    .dividend_i (dvd_y),
    .divisor_i  (dvs),
    .done_o     (done_y),
    .quotient_o (q_y)
  );

  // Both dividers always start together; the y quotient is ignored for the step fraction.
  assign stat_o.div_done = done_x && done_y;

  // Source range check for the current layer.
  logic ok_x, ok_y, ok;

  always_comb begin
    ok_x = (!n_x[NUM_W-1] || (q_x == '0)) && (q_x < DVD_W'(size_w));
    ok_y = (!n_y[NUM_W-1] || (q_y == '0)) && (q_y < DVD_W'(size_h));
    ok   = d_pos && ok_x && ok_y;
  end

  // Frame store addressing.
  logic [AW-1:0] src_addr, orig_addr, store_addr;
  logic          store_in;

  always_comb begin
    src_addr   = AW'(AW'(q_y[SIZE_W-1:0]) * AW'(MAX_WIDTH) + AW'(q_x[SIZE_W-1:0]));
    orig_addr  = AW'(AW'(py_q) * AW'(MAX_WIDTH) + AW'(px_q));
    store_addr = AW'(AW'(pixel_y_i) * AW'(MAX_WIDTH) + AW'(pixel_x_i));
    store_in   = (GEO_W'(pixel_x_i) < GEO_W'(MAX_WIDTH)) &&
                 (GEO_W'(pixel_y_i) < GEO_W'(MAX_HEIGHT));
  end

  // Frame store: one write port, one registered read port.
  logic [PIX_W-1:0] frame_mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  assign rd_en   = (cmd_i.layer_read && ok) || cmd_i.orig_read;
  assign rd_addr = cmd_i.orig_read ? orig_addr : src_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && store_in) begin
      frame_mem[store_addr] <= pixel_i;
    end
    if (rd_en) begin
      rdata_q <= frame_mem[rd_addr];
    end
  end

  // Per-item setup, layer walk and accumulation.
  logic             ok_q;
  logic [SUM_W-1:0] sum_q [NCH];
  logic [CH_IW-1:0] ch_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q  <= pixel_x_i;
      py_q  <= pixel_y_i;
      s_q   <= steps;
      for (int c = 0; c < NCH; c++) begin
        sum_q[c] <= '0;
      end
    end
    if (cmd_i.setup_a) begin
      ps_x_q <= 16'(px_q * s_q);
      ps_y_q <= 16'(py_q * s_q);
      wp_x_q <= 17'(size_w * center_x_q);
      wp_y_q <= 17'(size_h * center_y_q);
    end
    if (cmd_i.setup_b) begin
      p0_x_q  <= $signed(NUM_W'(ps_x_q * 30'd10000));
      p0_y_q  <= $signed(NUM_W'(ps_y_q * 30'd10000));
      k_x_q   <= K_W'(radius_s * $signed({1'b0, wp_x_q}));
      k_y_q   <= K_W'(radius_s * $signed({1'b0, wp_y_q}));
      acc_x_q <= '0;
      acc_y_q <= '0;
      m_q     <= $signed(M_W'(s_q * 21'd10000));
      mstep_q <= M_W'(radius_s * $signed(8'sd100));
      layer_q <= '0;
    end
    if (cmd_i.frac_take) begin
      frac_q <= q_x[FRAC_W-1:0];
      ch_q   <= '0;
    end
    if (cmd_i.layer_read) begin
      ok_q <= ok;
    end
    if (cmd_i.layer_acc) begin
      if (ok_q) begin
        for (int c = 0; c < NCH; c++) begin
          sum_q[c] <= sum_q[c] + SUM_W'(rdata_q[c*CH_W +: CH_W]);
        end
      end else if (color_mode_q) begin
        sum_q[2] <= sum_q[2] + zbp_pkg::CHROMA_FILL;
        sum_q[3] <= sum_q[3] + zbp_pkg::CHROMA_FILL;
      end
      acc_x_q <= acc_x_q + NUM_W'(k_x_q);
      acc_y_q <= acc_y_q + NUM_W'(k_y_q);
      m_q     <= m_q + mstep_q;
      layer_q <= layer_q + 1'b1;
    end
    if (cmd_i.scale) begin
      ch_q <= ch_q + 1'b1;
    end
  end

  assign stat_o.last_layer = (layer_q == s_q - 1'b1);
  assign stat_o.last_chan  = (ch_q == CH_IW'(NCH - 1));

  // Final scaling, one channel a cycle through one multiplier.
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  result_q;

  assign prod = sum_q[ch_q] * frac_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      if (chan_mask_q[ch_q]) begin
        result_q[ch_q*CH_W +: CH_W] <= prod[2*CH_W-1:CH_W];
      end else begin
        result_q[ch_q*CH_W +: CH_W] <= rdata_q[ch_q*CH_W +: CH_W];
      end
    end
  end

  assign result_o = result_q;

endmodule

### rtl/core/zoom_blur_pixel_engine.sv
// Zoom blur pixel engine.
// Items enter on the command port: an item is taken at a rising edge where start_i is high
// and busy_o is low. A store item (kind_i low) writes one pixel into the frame store in that
// same edge and leaves busy_o low, so stores can be issued every cycle.
// A compute item (kind_i high) names an output pixel. It raises busy_o, walks step_count
// zoom layers and then shows its word on out_a_o..out_d_o, marked by done_o high for
// exactly one cycle. A compute item outside the frame in use gives no word and does not
// raise busy_o. A compute item keeps busy_o high from when it is taken through the done_o
// cycle, and the next item is taken only after busy_o falls again.
// Each layer waits for two bit-serial dividers (one per axis) that form the rounded source
// coordinates, then one frame-store read and accumulate; 65536 / steps uses the dividers
// up front, and the four channels are scaled one per cycle through a shared multiplier.
// The receiver cannot stall: a word on the result ports is taken in the cycle it shows.
// Configuration registers are written over the cfg channel, which is always ready.
// Reset (rst_ni low) returns the registers to their defaults and the controller to idle.
// The frame store is not cleared; pixels must be stored before they are read.
module zoom_blur_pixel_engine #(
  parameter int MAX_WIDTH  = zbp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = zbp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_STEPS  = zbp_pkg::DEF_MAX_STEPS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [zbp_pkg::POS_W-1:0]   pixel_x_i,
  input  logic [zbp_pkg::POS_W-1:0]   pixel_y_i,
  input  logic [zbp_pkg::CH_W-1:0]    chan_a_i,
  input  logic [zbp_pkg::CH_W-1:0]    chan_b_i,
  input  logic [zbp_pkg::CH_W-1:0]    chan_c_i,
  input  logic [zbp_pkg::CH_W-1:0]    chan_d_i,
  output logic                        done_o,
  output logic [zbp_pkg::CH_W-1:0]    out_a_o,
  output logic [zbp_pkg::CH_W-1:0]    out_b_o,
  output logic [zbp_pkg::CH_W-1:0]    out_c_o,
  output logic [zbp_pkg::CH_W-1:0]    out_d_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [zbp_pkg::CFG_IW-1:0]  cfg_index_i,
  input  logic [zbp_pkg::CFG_DW-1:0]  cfg_data_i
);

  localparam int CH_W = zbp_pkg::CH_W;

  zbp_pkg::zbp_cmd_t  cmd;
  zbp_pkg::zbp_stat_t stat;
  logic [zbp_pkg::PIX_W-1:0] result;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Controller.
  zbp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Datapath with frame store and dividers.
  zbp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_STEPS  (MAX_STEPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .pixel_i     ({chan_d_i, chan_c_i, chan_b_i, chan_a_i}),
    .result_o    (result)
  );

  // Split the result word into channels.
  assign out_a_o = result[0*CH_W +: CH_W];
  assign out_b_o = result[1*CH_W +: CH_W];
  assign out_c_o = result[2*CH_W +: CH_W];
  assign out_d_o = result[3*CH_W +: CH_W];

endmodule

### verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int STORE_W   = 512;
  localparam int STEPS_MAX = 100;
  localparam int IDLE_LIMIT = 20000;
  localparam int POS_W  = zbp_pkg::POS_W;
  localparam int CH_W   = zbp_pkg::CH_W;
  localparam int CFG_IW = zbp_pkg::CFG_IW;
  localparam int CFG_DW = zbp_pkg::CFG_DW;

  // One directed row: a word to send and, for computes, the word to expect.
  typedef struct {
    bit          kind;
    int          x;
    int          y;
    logic [63:0] pix;
    logic [63:0] want;
  } row_t;

  // One configuration setting together with its share of random traffic.
  typedef struct {
    int          cx;
    int          cy;
    logic [7:0]  rad;
    int          steps;
    int          mask;
    int          mode;
    int          w;
    int          h;
    int          n_items;
    int          idle_pct;
  } setting_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                kind_i = 1'b0;
  logic [POS_W-1:0]    pixel_x_i = '0;
  logic [POS_W-1:0]    pixel_y_i = '0;
  logic [CH_W-1:0]     chan_a_i = '0;
  logic [CH_W-1:0]     chan_b_i = '0;
  logic [CH_W-1:0]     chan_c_i = '0;
  logic [CH_W-1:0]     chan_d_i = '0;
  logic                done_o;
  logic [CH_W-1:0]     out_a_o;
  logic [CH_W-1:0]     out_b_o;
  logic [CH_W-1:0]     out_c_o;
  logic [CH_W-1:0]     out_d_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IW-1:0]   cfg_index_i = '0;
  logic [CFG_DW-1:0]   cfg_data_i = '0;

  zoom_blur_pixel_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .kind_i      (kind_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .chan_a_i    (chan_a_i),
    .chan_b_i    (chan_b_i),
    .chan_c_i    (chan_c_i),
    .chan_d_i    (chan_d_i),
    .done_o      (done_o),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .out_d_o     (out_d_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the frame store and of the configuration registers.
  logic [63:0] frame_mem [int];
  int          cen_x = 50;
  int          cen_y = 50;
  logic [7:0]  radius = 8'd10;
  int          step_reg = 10;
  int          chan_mask = 15;
  int          ayuv = 0;
  int          width_reg = 512;
  int          height_reg = 512;

  logic [63:0] blur_q [$];
  int          err_count = 0;
  int          idle_pct = 0;
  int          sent_count = 0;

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic int eff_size(int v);
    if (v < 1) return 1;
    return v > STORE_W ? STORE_W : v;
  endfunction

  function automatic int eff_steps();
    if (step_reg == 0) return 1;
    return step_reg > STEPS_MAX ? STEPS_MAX : step_reg;
  endfunction

  function automatic longint round_near(longint n, longint m);
    if (n >= 0) return (2 * n + m) / (2 * m);
    return -((-2 * n + m) / (2 * m));
  endfunction

  // Source coordinate of one layer on one axis; returns whether it lies in the frame.
  function automatic bit layer_src(longint p, longint pct, longint size, longint i,
                                   output longint src);
    longint r;
    longint s;
    longint d;
    r = longint'($signed(radius));
    s = eff_steps();
    d = 100 * s + i * r;
    src = 0;
    if (d <= 0) return 1'b0;
    src = round_near(p * 10000 * s + r * size * pct * i, 100 * d);
    return src >= 0 && src < size;
  endfunction

  // Frame-store addresses that a compute at (x, y) reads.
  function automatic void layer_reads(int x, int y, ref int addrs[$]);
    longint sx;
    longint sy;
    bit okx;
    bit oky;
    for (int i = 0; i < eff_steps(); i++) begin
      okx = layer_src(x, cen_x, eff_size(width_reg), i, sx);
      oky = layer_src(y, cen_y, eff_size(height_reg), i, sy);
      if (okx && oky) addrs.push_back(int'(sy) * STORE_W + int'(sx));
    end
    addrs.push_back(y * STORE_W + x);
  endfunction

  // Blurred pixel at (x, y) under the current settings.
  function automatic logic [63:0] blur_pixel(int x, int y);
    longint unsigned sum [4];
    longint unsigned frac;
    longint sx;
    longint sy;
    bit okx;
    bit oky;
    logic [63:0] v;
    logic [63:0] orig;
    logic [63:0] res;
    for (int c = 0; c < 4; c++) sum[c] = 0;
    for (int i = 0; i < eff_steps(); i++) begin
      okx = layer_src(x, cen_x, eff_size(width_reg), i, sx);
      oky = layer_src(y, cen_y, eff_size(height_reg), i, sy);
      if (okx && oky) begin
        v = frame_mem[int'(sy) * STORE_W + int'(sx)];
        for (int c = 0; c < 4; c++) sum[c] += v[16*c +: 16];
      end else if (ayuv != 0) begin
        sum[2] += 'h8000;
        sum[3] += 'h8000;
      end
    end
    frac = 65536 / eff_steps();
    orig = frame_mem[y * STORE_W + x];
    for (int c = 0; c < 4; c++) begin
      if (chan_mask[c]) res[16*c +: 16] = 16'((sum[c] * frac) >> 16);
      else res[16*c +: 16] = orig[16*c +: 16];
    end
    return res;
  endfunction

  // Send one word on the command port and account for it once it is taken.
  task automatic send_word(bit kind, int x, int y, logic [63:0] pix, bit typed,
                           logic [63:0] want);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    kind_i    <= kind;
    pixel_x_i <= POS_W'(x);
    pixel_y_i <= POS_W'(y);
    chan_a_i  <= pix[15:0];
    chan_b_i  <= pix[31:16];
    chan_c_i  <= pix[47:32];
    chan_d_i  <= pix[63:48];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent_count++;
    if (!kind) frame_mem[y * STORE_W + x] = pix;
    else if (x < eff_size(width_reg) && y < eff_size(height_reg))
      blur_q.push_back(typed ? want : blur_pixel(x, y));
  endtask

  function automatic logic [63:0] rand_pix();
    return {$urandom(), $urandom()};
  endfunction

  // A compute inside the frame; pixels it would read that were never stored get stored first.
  task automatic compute_in_frame(int x, int y);
    int addrs [$];
    layer_reads(x, y, addrs);
    foreach (addrs[k]) begin
      if (!frame_mem.exists(addrs[k]))
        send_word(1'b0, addrs[k] % STORE_W, addrs[k] / STORE_W, rand_pix(), 1'b0, '0);
    end
    send_word(1'b1, x, y, '0, 1'b0, '0);
  endtask

  // Hold the sender off until the block has nothing left to deliver.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (blur_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic cfg_write(zbp_pkg::cfg_reg_e idx, logic [CFG_DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      zbp_pkg::REG_CENTER_X:    cen_x = data[6:0];
      zbp_pkg::REG_CENTER_Y:    cen_y = data[6:0];
      zbp_pkg::REG_ZOOM_RADIUS: radius = data[7:0];
      zbp_pkg::REG_STEP_COUNT:  step_reg = data[6:0];
      zbp_pkg::REG_CHAN_MASK:   chan_mask = data[3:0];
      zbp_pkg::REG_COLOR_MODE:  ayuv = data[0];
      zbp_pkg::REG_FRAME_W:     width_reg = data;
      zbp_pkg::REG_FRAME_H:     height_reg = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(setting_t s);
    cfg_write(zbp_pkg::REG_CENTER_X, CFG_DW'(s.cx));
    cfg_write(zbp_pkg::REG_CENTER_Y, CFG_DW'(s.cy));
    cfg_write(zbp_pkg::REG_ZOOM_RADIUS, {2'b00, s.rad});
    cfg_write(zbp_pkg::REG_STEP_COUNT, CFG_DW'(s.steps));
    cfg_write(zbp_pkg::REG_CHAN_MASK, CFG_DW'(s.mask));
    cfg_write(zbp_pkg::REG_COLOR_MODE, CFG_DW'(s.mode));
    cfg_write(zbp_pkg::REG_FRAME_W, CFG_DW'(s.w));
    cfg_write(zbp_pkg::REG_FRAME_H, CFG_DW'(s.h));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checker: every word on the result ports must match the oldest expectation.
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && done_o) begin
      if (blur_q.size() == 0) begin
        report("unexpected word", out_a_o, 'x);
      end else begin
        want = blur_q.pop_front();
        if (out_a_o !== want[15:0])  report("out_a", out_a_o, want[15:0]);
        if (out_b_o !== want[31:16]) report("out_b", out_b_o, want[31:16]);
        if (out_c_o !== want[47:32]) report("out_c", out_c_o, want[47:32]);
        if (out_d_o !== want[63:48]) report("out_d", out_d_o, want[63:48]);
      end
    end
  end

  // Watchdog: give up after a long stretch in which nothing moves on any port.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed words, run with a single layer so each result is the stored pixel itself.
  row_t rows [] = '{
    '{1'b0,   0,   0, 64'h0000_0000_0000_0000, 64'h0},
    '{1'b1,   0,   0, 64'h0,                   64'h0000_0000_0000_0000},
    '{1'b0, 511, 511, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
    '{1'b1, 511, 511, 64'h0,                   64'hFFFF_FFFF_FFFF_FFFF},
    '{1'b0, 511,   0, 64'hAAAA_5555_AAAA_5555, 64'h0},
    '{1'b1, 511,   0, 64'h0,                   64'hAAAA_5555_AAAA_5555},
    '{1'b0,   0, 511, 64'hFEDC_1234_5555_AAAA, 64'h0},
    '{1'b1,   0, 511, 64'h0,                   64'hFEDC_1234_5555_AAAA},
    '{1'b0, 256, 255, 64'hFFFE_0001_7FFF_8000, 64'h0},
    '{1'b1, 256, 255, 64'h0,                   64'hFFFE_0001_7FFF_8000}
  };

  // Settings swept by the random part, extremes of every register among them.
  // The item share of a setting counts every word sent, the fill stores included.
  setting_t plan [] = '{
    '{ 50,  50, 8'd10,   4, 15, 0,    8,    8, 110,  0},
    '{  0, 100, 8'h9C,   7,  5, 1,   12,    6, 110, 52},
    '{127, 127, 8'd127, 127, 15, 1,    5,    4,  25, 17},
    '{ 30,  70, 8'h80,   6, 10, 1,   16,   16, 110,  0},
    '{100,   0, 8'hCE,   0,  3, 0, 1023,    0, 110, 52},
    '{ 50,  50, 8'd100,  2, 15, 1,  512,  512, 110, 17},
    '{ 25,  75, 8'hEC,  12,  0, 0,    0, 1023,  80,  0},
    '{ 60,  40, 8'd45,   3,  9, 1,   20,    3, 110, 52}
  };

  initial begin
    int w;
    int h;
    int pick;
    int base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults after reset: the center pixel maps onto itself in every layer.
    compute_in_frame(256, 256);
    drain();
    cfg_write(zbp_pkg::REG_STEP_COUNT, CFG_DW'(1));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    step_reg = 1;
    foreach (rows[k]) send_word(rows[k].kind, rows[k].x, rows[k].y, rows[k].pix, 1'b1,
                                rows[k].want);
    drain();

    foreach (plan[p]) begin
      apply_setting(plan[p]);
      idle_pct = plan[p].idle_pct;
      w = eff_size(width_reg);
      h = eff_size(height_reg);
      base = sent_count;
      for (int n = 0; sent_count - base < plan[p].n_items; n++) begin
        if (p == 1 && n == plan[p].n_items / 4) drain();
        pick = $urandom_range(99);
        if (pick < 25) begin
          send_word(1'b0, $urandom_range(511), $urandom_range(511), rand_pix(), 1'b0, '0);
        end else if (pick < 35 && w < STORE_W) begin
          send_word(1'b1, $urandom_range(STORE_W - 1, w), $urandom_range(511), '0, 1'b0, '0);
        end else if (pick < 35 && h < STORE_W) begin
          send_word(1'b1, $urandom_range(w - 1), $urandom_range(STORE_W - 1, h), '0, 1'b0,
                    '0);
        end else begin
          compute_in_frame($urandom_range(w - 1), $urandom_range(h - 1));
        end
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
